>>> src/pws_pkg.sv
`timescale 1ns / 1ps

package pws_pkg;

    localparam int COORD_W  = 16;
    localparam int CFG_W    = 13;
    localparam int CLIP_W   = 18;
    localparam int WIDE_W   = 16;
    localparam int H_W      = 13;
    localparam int V_W      = 11;
    localparam int RB_W     = 11;
    localparam int OFF_W    = 12;
    localparam int ROW_W    = 12;

    localparam int PANEL_W_RST = 1200;
    localparam int PANEL_H_RST = 1600;

    localparam logic CHIP_LEFT  = 1'b0;
    localparam logic CHIP_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        CFG_PANEL_WIDTH  = 2'd0,
        CFG_PANEL_HEIGHT = 2'd1,
        CFG_ROTATION     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef struct packed {
        logic signed [COORD_W-1:0] win_x;
        logic signed [COORD_W-1:0] win_y;
        logic signed [COORD_W-1:0] win_w;
        logic signed [COORD_W-1:0] win_h;
    } t_win_in;

    typedef struct packed {
        logic             chip_sel;
        logic             chip_needed;
        logic [H_W-1:0]   h_start;
        logic [H_W-1:0]   h_end;
        logic [V_W-1:0]   v_start;
        logic [V_W-1:0]   v_end;
        logic [RB_W-1:0]  row_bytes;
        logic [OFF_W-1:0] buf_col_offset;
        logic [ROW_W-1:0] first_row;
        logic [ROW_W-1:0] final_row;
        logic             last;
    } t_chip_out;

endpackage

>>> src/pws_clip.sv
`timescale 1ns / 1ps

module pws_clip #(
    parameter int DIM_W = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pws_pkg::t_win_in      i_win,
    input  logic [DIM_W-1:0]      i_panel_w,
    input  logic [DIM_W-1:0]      i_panel_h,
    input  pws_pkg::t_rot         i_rot,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DIM_W-1:0]      o_x,
    output logic [DIM_W-1:0]      o_y,
    output logic [DIM_W-1:0]      o_w,
    output logic [DIM_W-1:0]      o_h,
    output logic                  o_empty
);

    localparam int CW = pws_pkg::CLIP_W;

    logic signed [CW-1:0] x_e, y_e, w_e, h_e;
    logic signed [CW-1:0] n1_x, n1_y, n1_w, n1_h;
    logic signed [CW-1:0] r1_x, r1_y, r1_w, r1_h;
    logic                 r1_v;
    logic                 en1, en2;

    logic                 swap;
    logic signed [CW-1:0] gw, gh, xsum, ysum;
    logic [DIM_W-1:0]     n2_x, n2_y, n2_w, n2_h;
    logic                 n2_empty;
    logic [DIM_W-1:0]     r2_x, r2_y, r2_w, r2_h;
    logic                 r2_empty;
    logic                 r2_v;

    assign en2     = !r2_v || i_ready;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    assign x_e = CW'($signed(i_win.win_x));
    assign y_e = CW'($signed(i_win.win_y));
    assign w_e = CW'($signed(i_win.win_w));
    assign h_e = CW'($signed(i_win.win_h));

    // drop the part left of or above the canvas origin
    always_comb begin
        n1_x = x_e[CW-1] ? '0 : x_e;
        n1_w = x_e[CW-1] ? w_e + x_e : w_e;
        n1_y = y_e[CW-1] ? '0 : y_e;
        n1_h = y_e[CW-1] ? h_e + y_e : h_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x <= n1_x;
            r1_y <= n1_y;
            r1_w <= n1_w;
            r1_h <= n1_h;
        end
    end

    // clip against the far canvas edges
    always_comb begin
        swap     = (i_rot == pws_pkg::ROT_90) || (i_rot == pws_pkg::ROT_270);
        gw       = $signed(CW'(swap ? i_panel_h : i_panel_w));
        gh       = $signed(CW'(swap ? i_panel_w : i_panel_h));
        xsum     = r1_x + r1_w;
        ysum     = r1_y + r1_h;
        n2_empty = r1_w[CW-1] || (r1_w == '0) || r1_h[CW-1] || (r1_h == '0)
                   || (r1_x >= gw) || (r1_y >= gh);
        n2_x     = DIM_W'(r1_x);
        n2_y     = DIM_W'(r1_y);
        n2_w     = (xsum > gw) ? DIM_W'(gw - r1_x) : DIM_W'(r1_w);
        n2_h     = (ysum > gh) ? DIM_W'(gh - r1_y) : DIM_W'(r1_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_x     <= n2_x;
            r2_y     <= n2_y;
            r2_w     <= n2_w;
            r2_h     <= n2_h;
            r2_empty <= n2_empty;
        end
    end

    assign o_valid = r2_v;
    assign o_x     = r2_x;
    assign o_y     = r2_y;
    assign o_w     = r2_w;
    assign o_h     = r2_h;
    assign o_empty = r2_empty;

endmodule

>>> src/pws_map.sv
`timescale 1ns / 1ps

module pws_map #(
    parameter int DIM_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [DIM_W-1:0] i_x,
    input  logic [DIM_W-1:0] i_y,
    input  logic [DIM_W-1:0] i_w,
    input  logic [DIM_W-1:0] i_h,
    input  logic             i_empty,
    input  logic [DIM_W-1:0] i_panel_w,
    input  logic [DIM_W-1:0] i_panel_h,
    input  pws_pkg::t_rot    i_rot,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DIM_W-1:0] o_cs,
    output logic [DIM_W-1:0] o_ce,
    output logic [DIM_W-1:0] o_rs,
    output logic [DIM_W-1:0] o_re,
    output logic             o_empty
);

    localparam logic [DIM_W-1:0] ONE   = DIM_W'(1);
    localparam logic [DIM_W-1:0] THREE = DIM_W'(3);

    logic             en3, en4;
    logic [DIM_W-1:0] n3_cs, n3_ce, n3_rs, n3_re;
    logic [DIM_W-1:0] r3_cs, r3_ce, r3_rs, r3_re;
    logic             r3_empty, r3_v;

    logic [DIM_W-1:0] ce_or, re_or;
    logic [DIM_W-1:0] n4_cs, n4_ce, n4_rs, n4_re;
    logic [DIM_W-1:0] r4_cs, r4_ce, r4_rs, r4_re;
    logic             r4_empty, r4_v;

    assign en4     = !r4_v || i_ready;
    assign en3     = !r3_v || en4;
    assign o_ready = en3;

    always_comb begin
        unique case (i_rot)
            pws_pkg::ROT_90: begin
                n3_cs = i_panel_w - i_y - i_h;
                n3_ce = i_panel_w - ONE - i_y;
                n3_rs = i_x;
                n3_re = i_x + i_w - ONE;
            end
            pws_pkg::ROT_180: begin
                n3_cs = i_x;
                n3_ce = i_x + i_w - ONE;
                n3_rs = i_y;
                n3_re = i_y + i_h - ONE;
            end
            pws_pkg::ROT_270: begin
                n3_cs = i_y;
                n3_ce = i_y + i_h - ONE;
                n3_rs = i_panel_h - i_x - i_w;
                n3_re = i_panel_h - ONE - i_x;
            end
            default: begin
                n3_cs = i_panel_w - i_x - i_w;
                n3_ce = i_panel_w - ONE - i_x;
                n3_rs = i_panel_h - i_y - i_h;
                n3_re = i_panel_h - ONE - i_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_cs    <= n3_cs;
            r3_ce    <= n3_ce;
            r3_rs    <= n3_rs;
            r3_re    <= n3_re;
            r3_empty <= i_empty;
        end
    end

    // widen columns to groups of four and rows to even/odd pairs, then clamp
    always_comb begin
        ce_or = r3_ce | THREE;
        re_or = r3_re | ONE;
        n4_cs = r3_cs & ~THREE;
        n4_ce = (ce_or >= i_panel_w) ? i_panel_w - ONE : ce_or;
        n4_rs = r3_rs & ~ONE;
        n4_re = (re_or >= i_panel_h) ? i_panel_h - ONE : re_or;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_cs    <= n4_cs;
            r4_ce    <= n4_ce;
            r4_rs    <= n4_rs;
            r4_re    <= n4_re;
            r4_empty <= r3_empty;
        end
    end

    assign o_valid = r4_v;
    assign o_cs    = r4_cs;
    assign o_ce    = r4_ce;
    assign o_rs    = r4_rs;
    assign o_re    = r4_re;
    assign o_empty = r4_empty;

endmodule

>>> src/pws_split.sv
`timescale 1ns / 1ps

module pws_split #(
    parameter int DIM_W = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [DIM_W-1:0]    i_cs,
    input  logic [DIM_W-1:0]    i_ce,
    input  logic [DIM_W-1:0]    i_rs,
    input  logic [DIM_W-1:0]    i_re,
    input  logic                i_empty,
    input  logic [DIM_W-1:0]    i_panel_w,
    output logic                o_valid,
    input  logic                i_ready,
    output pws_pkg::t_chip_out  o_chip
);

    localparam int WW   = pws_pkg::WIDE_W;
    localparam int HW   = pws_pkg::H_W;
    localparam int VW   = pws_pkg::V_W;
    localparam int RBW  = pws_pkg::RB_W;
    localparam int OFW  = pws_pkg::OFF_W;
    localparam int RWW  = pws_pkg::ROW_W;

    localparam logic [WW-1:0] W_ONE = WW'(1);

    function automatic pws_pkg::t_chip_out make_chip(
        input logic          sel,
        input logic          need,
        input logic [WW-1:0] lcs,
        input logic [WW-1:0] lce,
        input logic [WW-1:0] rs,
        input logic [WW-1:0] re,
        input logic [WW-1:0] off
    );
        pws_pkg::t_chip_out c;
        c = '0;
        c.chip_sel = sel;
        c.last     = sel;
        if (need) begin
            c.chip_needed    = 1'b1;
            c.h_start        = HW'(lcs << 1);
            c.h_end          = HW'((lce << 1) | W_ONE);
            c.v_start        = VW'(rs >> 1);
            c.v_end          = VW'(((re + W_ONE) >> 1) - W_ONE);
            c.row_bytes      = RBW'((lce - lcs + W_ONE) >> 1);
            c.buf_col_offset = OFW'(off);
            c.first_row      = RWW'(rs);
            c.final_row      = RWW'(re);
        end
        return c;
    endfunction

    logic             en5, pfree;
    logic [DIM_W-1:0] halfw;
    logic             n5_mneed, n5_sneed;
    logic [DIM_W-1:0] n5_mlce, n5_slcs, n5_slce;
    logic             r5_v, r5_mneed, r5_sneed;
    logic [DIM_W-1:0] r5_mlcs, r5_mlce, r5_slcs, r5_slce, r5_rs, r5_re, r5_halfb;

    logic [WW-1:0]       m_off, s_off;
    pws_pkg::t_chip_out  n6_m, n6_s;
    pws_pkg::t_chip_out  r6_m, r6_s;
    logic                r6_v, r6_ph;

    // the pair register frees when it is empty or the slave transaction leaves
    assign pfree   = !r6_v || (r6_ph && i_ready);
    assign en5     = !r5_v || pfree;
    assign o_ready = en5;

    always_comb begin
        halfw    = i_panel_w >> 1;
        n5_mneed = !i_empty && (i_cs < halfw);
        n5_mlce  = (i_ce < halfw) ? i_ce : halfw - DIM_W'(1);
        n5_sneed = !i_empty && (i_ce >= halfw);
        n5_slcs  = (i_cs >= halfw) ? i_cs - halfw : '0;
        n5_slce  = i_ce - halfw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en5) begin
            r5_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_mneed <= n5_mneed;
            r5_sneed <= n5_sneed;
            r5_mlcs  <= i_cs;
            r5_mlce  <= n5_mlce;
            r5_slcs  <= n5_slcs;
            r5_slce  <= n5_slce;
            r5_rs    <= i_rs;
            r5_re    <= i_re;
            r5_halfb <= halfw >> 1;
        end
    end

    always_comb begin
        m_off = WW'(r5_mlcs) >> 1;
        s_off = WW'(r5_halfb) + (WW'(r5_slcs) >> 1);
        n6_m  = make_chip(pws_pkg::CHIP_LEFT, r5_mneed, WW'(r5_mlcs), WW'(r5_mlce),
                          WW'(r5_rs), WW'(r5_re), m_off);
        n6_s  = make_chip(pws_pkg::CHIP_RIGHT, r5_sneed, WW'(r5_slcs), WW'(r5_slce),
                          WW'(r5_rs), WW'(r5_re), s_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v  <= 1'b0;
            r6_ph <= 1'b0;
        end else if (pfree) begin
            r6_v  <= r5_v;
            r6_ph <= 1'b0;
        end else if (i_ready) begin
            r6_ph <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pfree) begin
            r6_m <= n6_m;
            r6_s <= n6_s;
        end
    end

    assign o_valid = r6_v;
    assign o_chip  = r6_ph ? r6_s : r6_m;

endmodule

>>> src/partial_window_split.sv
`timescale 1ns / 1ps

// Partial window splitter: takes one update rectangle in rotated logical
// coordinates per transaction on the input channel and returns two result
// transactions, master chip then slave chip (last set on the slave one).
// The work runs through six register stages: two clip stages, rotation map,
// alignment, chip split, and the pair register that holds both built results
// and drives the output. The slave result follows in the cycle after the
// master is taken. The pair register sends one result per cycle while the
// output is ready and takes a new window once both results of the last one
// have been taken; output stalls back up through the pipeline without loss.
// Panel width and height are saturated to MAX_PANEL_DIM when written. The
// configuration port is always ready; write it only while no window is in
// flight.

module partial_window_split #(
    parameter int MAX_PANEL_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pws_pkg::t_win_in                i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pws_pkg::t_chip_out              o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pws_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_PANEL_DIM + 1);
    localparam int SW    = pws_pkg::CFG_W + 1;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_PANEL_DIM);
    localparam logic [DIM_W-1:0] W_RST   =
        DIM_W'((pws_pkg::PANEL_W_RST > MAX_PANEL_DIM) ? MAX_PANEL_DIM : pws_pkg::PANEL_W_RST);
    localparam logic [DIM_W-1:0] H_RST   =
        DIM_W'((pws_pkg::PANEL_H_RST > MAX_PANEL_DIM) ? MAX_PANEL_DIM : pws_pkg::PANEL_H_RST);

    logic [DIM_W-1:0]  r_panel_w, r_panel_h;
    pws_pkg::t_rot     r_rot;
    logic [DIM_W-1:0]  sat_data;

    logic              c_valid, c_ready, c_empty;
    logic [DIM_W-1:0]  c_x, c_y, c_w, c_h;
    logic              m_valid, m_ready, m_empty;
    logic [DIM_W-1:0]  m_cs, m_ce, m_rs, m_re;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        sat_data = ({1'b0, i_cfg_data} > SW'(MAX_PANEL_DIM)) ? DIM_MAX : DIM_W'(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= W_RST;
            r_panel_h <= H_RST;
            r_rot     <= pws_pkg::ROT_0;
        end else if (i_cfg_valid) begin
            unique case (pws_pkg::t_cfg_idx'(i_cfg_index))
                pws_pkg::CFG_PANEL_WIDTH:  r_panel_w <= sat_data;
                pws_pkg::CFG_PANEL_HEIGHT: r_panel_h <= sat_data;
                pws_pkg::CFG_ROTATION:     r_rot     <= pws_pkg::t_rot'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    pws_clip #(
        .DIM_W (DIM_W)
    ) u_clip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_win     (i_in),
        .i_panel_w (r_panel_w),
        .i_panel_h (r_panel_h),
        .i_rot     (r_rot),
        .o_valid   (c_valid),
        .i_ready   (c_ready),
        .o_x       (c_x),
        .o_y       (c_y),
        .o_w       (c_w),
        .o_h       (c_h),
        .o_empty   (c_empty)
    );

    pws_map #(
        .DIM_W (DIM_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_valid),
        .o_ready   (c_ready),
        .i_x       (c_x),
        .i_y       (c_y),
        .i_w       (c_w),
        .i_h       (c_h),
        .i_empty   (c_empty),
        .i_panel_w (r_panel_w),
        .i_panel_h (r_panel_h),
        .i_rot     (r_rot),
        .o_valid   (m_valid),
        .i_ready   (m_ready),
        .o_cs      (m_cs),
        .o_ce      (m_ce),
        .o_rs      (m_rs),
        .o_re      (m_re),
        .o_empty   (m_empty)
    );

    pws_split #(
        .DIM_W (DIM_W)
    ) u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (m_valid),
        .o_ready   (m_ready),
        .i_cs      (m_cs),
        .i_ce      (m_ce),
        .i_rs      (m_rs),
        .i_re      (m_re),
        .i_empty   (m_empty),
        .i_panel_w (r_panel_w),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_chip    (o_out)
    );

endmodule

>>> src/pws_chk.sv
`timescale 1ns / 1ps

module pws_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pws_pkg::t_chip_out i_out
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("output transaction changed while stalled");

    // slave result directly follows an accepted master result
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out.last |=> i_out_valid && i_out.last)
        else $error("slave result missing after master");

    a_sel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.chip_sel == i_out.last)
        else $error("chip select and last disagree");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.chip_needed |->
            i_out.h_start == '0 && i_out.h_end == '0 && i_out.v_start == '0 &&
            i_out.v_end == '0 && i_out.row_bytes == '0 && i_out.buf_col_offset == '0 &&
            i_out.first_row == '0 && i_out.final_row == '0)
        else $error("unused chip carries nonzero fields");

    a_alignment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.chip_needed |->
            !i_out.first_row[0] && !i_out.h_start[0] && i_out.h_end[0])
        else $error("window bounds not aligned");

endmodule

bind partial_window_split pws_chk u_pws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
